>>> rtl/core/local_minimum_3x3_finder_macros.svh
// Assertion helpers shared by the local minimum finder.
`ifndef LOCAL_MINIMUM_3X3_FINDER_MACROS_SVH
`define LOCAL_MINIMUM_3X3_FINDER_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define LMF_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("local minimum finder check failed");

// The consequent holds at the clock edge after the antecedent.
`define LMF_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("local minimum finder check failed");

`endif

>>> rtl/core/lmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmf_pkg;

   localparam int CNT_BITS       = 10;
   localparam int IDX_BITS       = 9;
   localparam int MAX_ROWS       = 512;
   localparam int RESET_SIZE     = 512;
   localparam int DEF_MAX_COLS   = 512;
   localparam int DEF_VALUE_BITS = 16;
   localparam int CSR_ADDR_BITS  = 2;
   localparam int OUT_DEPTH      = 3;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_NUM_ROWS = 2'd0,
      REG_NUM_COLS = 2'd1
   } csr_reg_type;

   typedef struct packed {
      logic                emit;
      logic                done;
      logic                at_top;
      logic                at_bottom;
      logic                at_left;
      logic                at_right;
      logic [IDX_BITS-1:0] row;
      logic [IDX_BITS-1:0] col;
   } s1_ctrl_type;

   function automatic logic [CNT_BITS-1:0] clamp_size(input logic [CNT_BITS-1:0] v,
                                                      input int hi);
      logic [CNT_BITS-1:0] r;
      r = v;
      if (v == '0) begin
         r = CNT_BITS'(1);
      end else if (int'(v) > hi) begin
         r = CNT_BITS'(hi);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/lmf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/lmf_window.sv
`timescale 1ns / 1ps
`default_nettype none

module lmf_window #(
   parameter int VALUE_BITS = lmf_pkg::DEF_VALUE_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           step,
   input  wire lmf_pkg::s1_ctrl_type           ctrl,
   input  wire logic signed [VALUE_BITS-1:0]   up_value,
   input  wire logic signed [VALUE_BITS-1:0]   lo_value,
   input  wire logic signed [VALUE_BITS-1:0]   new_value,
   output logic                                res_valid,
   output logic [lmf_pkg::IDX_BITS-1:0]        res_row,
   output logic [lmf_pkg::IDX_BITS-1:0]        res_col,
   output logic signed [VALUE_BITS-1:0]        res_value,
   output logic                                res_min,
   output logic                                res_done
);

   import lmf_pkg::*;

   logic signed [VALUE_BITS-1:0] mid_ff  [3];
   logic signed [VALUE_BITS-1:0] mid_in  [3];
   logic signed [VALUE_BITS-1:0] tail_ff [3];
   logic signed [VALUE_BITS-1:0] tail_in [3];
   logic signed [VALUE_BITS-1:0] incoming [3];
   logic signed [VALUE_BITS-1:0] nb [3][3];
   logic signed [VALUE_BITS-1:0] centre;
   logic                         keep [3][3];
   logic                         is_min;

   always_comb begin
      incoming[0] = up_value;
      incoming[1] = lo_value;
      incoming[2] = new_value;
      centre      = tail_ff[1];
      is_min      = 1'b1;
      for (int r = 0; r < 3; r++) begin
         mid_in[r]  = tail_ff[r];
         tail_in[r] = incoming[r];
         nb[r][0]   = mid_ff[r];
         nb[r][1]   = tail_ff[r];
         nb[r][2]   = incoming[r];
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            keep[r][c] = !((r == 0) && ctrl.at_top) && !((r == 2) && ctrl.at_bottom) &&
                         !((c == 0) && ctrl.at_left) && !((c == 2) && ctrl.at_right);
            if (keep[r][c] && (centre > nb[r][c])) begin
               is_min = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            mid_ff[r]  <= '0;
            tail_ff[r] <= '0;
         end
      end else if (step) begin
         for (int r = 0; r < 3; r++) begin
            mid_ff[r]  <= mid_in[r];
            tail_ff[r] <= tail_in[r];
         end
      end
   end

   assign res_valid = step && ctrl.emit;
   assign res_row   = ctrl.row;
   assign res_col   = ctrl.col;
   assign res_value = centre;
   assign res_min   = is_min;
   assign res_done  = ctrl.done;

endmodule

`default_nettype wire

>>> rtl/core/lmf_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module lmf_out_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = lmf_pkg::OUT_DEPTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [WIDTH-1:0]             push_data,
   output logic                              pop_valid,
   input  wire logic                         pop_ready,
   output logic [WIDTH-1:0]                  pop_data,
   output logic [$clog2(DEPTH+1)-1:0]        fill
);

   localparam int PTR_BITS  = $clog2(DEPTH);
   localparam int FILL_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     entries_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic                 pop;

   always_comb begin
      pop       = pop_valid && pop_ready;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      fill_in = fill_ff + FILL_BITS'(push) - FILL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = (fill_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign fill      = fill_ff;

endmodule

`default_nettype wire

>>> rtl/core/local_minimum_3x3_finder.sv
// Finds local minima in a matrix streamed in raster order, one element per item.
// Configure num_rows (index 0) and num_cols (index 1) over the csr channel while
// the block is idle; either write restarts the frame at row 0, column 0.
// Send the rows*cols elements on the req channel with action 0, then num_cols+1
// drain items with action 1. Each element is decided one row and one column
// behind the input, and its result item (position, value, minimum flag and
// frame_done on the last element) leaves on the rsp channel.
// Throughput is one item per clock while req_ready is high. A result item shows
// on rsp_valid once queued: the edge that accepts the item that decides it reads
// the line stores into the s1 registers, and the edge on which s1 steps
// updates the window and queues the result. The line stores are two
// single-port-write RAMs of MAX_COLS entries with registered reads; a read that
// hits the entry written in the same cycle is served by forwarding.
// Results wait in a three-entry output queue, so a stalled receiver does not stop
// intake until the compare stage and the queue together hold three items;
// req_ready then drops.
// Reset empties the queue, zeroes the window and position counters and sets both
// sizes to 512. The line stores are not cleared and need no start-up pass.
`timescale 1ns / 1ps
`default_nettype none
`include "local_minimum_3x3_finder_macros.svh"

module local_minimum_3x3_finder #(
   parameter int MAX_COLS   = lmf_pkg::DEF_MAX_COLS,
   parameter int VALUE_BITS = lmf_pkg::DEF_VALUE_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_action,
   input  wire logic signed [VALUE_BITS-1:0]        req_pixel_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [lmf_pkg::IDX_BITS-1:0]             rsp_row_index,
   output logic [lmf_pkg::IDX_BITS-1:0]             rsp_col_index,
   output logic signed [VALUE_BITS-1:0]             rsp_element_value,
   output logic                                     rsp_is_minimum,
   output logic                                     rsp_frame_done,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lmf_pkg::CSR_ADDR_BITS-1:0]   csr_index,
   input  wire logic [lmf_pkg::CNT_BITS-1:0]        csr_data
);

   import lmf_pkg::*;

   localparam int ADDR_BITS = $clog2(MAX_COLS);
   localparam int RES_BITS  = 2 * IDX_BITS + VALUE_BITS + 2;
   localparam int FILL_BITS = $clog2(OUT_DEPTH + 1);

   logic [CNT_BITS-1:0]          rows_ff, rows_in;
   logic [CNT_BITS-1:0]          cols_ff, cols_in;
   logic [CNT_BITS-1:0]          row_ff, row_in;
   logic [CNT_BITS-1:0]          col_ff, col_in;
   logic [CNT_BITS-1:0]          col_eff, col_next, q_row, q_col;
   logic                         in_frame, skip, req_fire, take, csr_fire;
   logic signed [VALUE_BITS-1:0] value0;
   logic [ADDR_BITS-1:0]         rd_addr;
   s1_ctrl_type                  ctrl0;

   logic                         s1_valid_ff;
   s1_ctrl_type                  s1_ctrl_ff;
   logic [ADDR_BITS-1:0]         s1_addr_ff;
   logic signed [VALUE_BITS-1:0] s1_value_ff;
   logic                         s1_fwd_ff;
   logic signed [VALUE_BITS-1:0] fwd_up_ff, fwd_lo_ff;
   logic signed [VALUE_BITS-1:0] ram_up, ram_lo, up_eff, lo_eff;

   logic                         res_valid, res_min, res_done;
   logic [IDX_BITS-1:0]          res_row, res_col;
   logic signed [VALUE_BITS-1:0] res_value;
   logic [RES_BITS-1:0]          res_data, rsp_data;
   logic [FILL_BITS-1:0]         fill;
   logic [FILL_BITS:0]           occ;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign occ       = {1'b0, fill} + (FILL_BITS + 1)'(s1_valid_ff);
   assign req_ready = occ < (FILL_BITS + 1)'(OUT_DEPTH);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      col_eff   = (col_ff >= cols_ff) ? '0 : col_ff;
      in_frame  = row_ff < rows_ff;
      skip      = req_action && in_frame;
      take      = req_fire && !skip;
      value0    = in_frame ? req_pixel_value : '0;
      rd_addr   = ADDR_BITS'(col_eff);
      col_next  = col_eff + CNT_BITS'(1);
      q_row     = (col_eff == '0) ? row_ff - CNT_BITS'(2) : row_ff - CNT_BITS'(1);
      q_col     = (col_eff == '0) ? cols_ff - CNT_BITS'(1) : col_eff - CNT_BITS'(1);

      ctrl0.emit      = !((row_ff == '0) || ((row_ff == CNT_BITS'(1)) && (col_eff == '0))) &&
                        (q_row < rows_ff);
      ctrl0.done      = ctrl0.emit && (q_row == rows_ff - CNT_BITS'(1)) &&
                        (q_col == cols_ff - CNT_BITS'(1));
      ctrl0.at_top    = (q_row == '0);
      ctrl0.at_bottom = (q_row + CNT_BITS'(1)) >= rows_ff;
      ctrl0.at_left   = (q_col == '0);
      ctrl0.at_right  = (q_col + CNT_BITS'(1)) >= cols_ff;
      ctrl0.row       = q_row[IDX_BITS-1:0];
      ctrl0.col       = q_col[IDX_BITS-1:0];

      rows_in = rows_ff;
      cols_in = cols_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (csr_fire) begin
         case (csr_index)
            REG_NUM_ROWS: begin
               rows_in = clamp_size(csr_data, MAX_ROWS);
               row_in  = '0;
               col_in  = '0;
            end
            REG_NUM_COLS: begin
               cols_in = clamp_size(csr_data, MAX_COLS);
               row_in  = '0;
               col_in  = '0;
            end
            default: begin
               rows_in = rows_ff;
            end
         endcase
      end else if (take) begin
         if (ctrl0.done) begin
            row_in = '0;
            col_in = '0;
         end else if (col_next >= cols_ff) begin
            row_in = row_ff + CNT_BITS'(1);
            col_in = '0;
         end else begin
            col_in = col_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff     <= clamp_size(CNT_BITS'(RESET_SIZE), MAX_ROWS);
         cols_ff     <= clamp_size(CNT_BITS'(RESET_SIZE), MAX_COLS);
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         rows_ff     <= rows_in;
         cols_ff     <= cols_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_ctrl_ff  <= ctrl0;
         s1_addr_ff  <= rd_addr;
         s1_value_ff <= value0;
         s1_fwd_ff   <= s1_valid_ff && (s1_addr_ff == rd_addr);
         fwd_up_ff   <= lo_eff;
         fwd_lo_ff   <= s1_value_ff;
      end
   end

   assign up_eff = s1_fwd_ff ? fwd_up_ff : ram_up;
   assign lo_eff = s1_fwd_ff ? fwd_lo_ff : ram_lo;

   lmf_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_COLS)
   ) u_upper (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (lo_eff),
      .rd_en   (take),
      .rd_addr (rd_addr),
      .rd_data (ram_up)
   );

   lmf_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_COLS)
   ) u_lower (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_value_ff),
      .rd_en   (take),
      .rd_addr (rd_addr),
      .rd_data (ram_lo)
   );

   lmf_window #(
      .VALUE_BITS (VALUE_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_valid_ff),
      .ctrl      (s1_ctrl_ff),
      .up_value  (up_eff),
      .lo_value  (lo_eff),
      .new_value (s1_value_ff),
      .res_valid (res_valid),
      .res_row   (res_row),
      .res_col   (res_col),
      .res_value (res_value),
      .res_min   (res_min),
      .res_done  (res_done)
   );

   assign res_data = {res_row, res_col, res_value, res_min, res_done};

   lmf_out_fifo #(
      .WIDTH (RES_BITS),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_data  (rsp_data),
      .fill      (fill)
   );

   assign rsp_row_index     = rsp_data[RES_BITS-1 -: IDX_BITS];
   assign rsp_col_index     = rsp_data[RES_BITS-IDX_BITS-1 -: IDX_BITS];
   assign rsp_element_value = rsp_data[VALUE_BITS+1:2];
   assign rsp_is_minimum    = rsp_data[1];
   assign rsp_frame_done    = rsp_data[0];

   `LMF_ASSERT_ALWAYS(a_queue_bound, clock, reset, occ <= (FILL_BITS + 1)'(OUT_DEPTH))
   `LMF_ASSERT_ALWAYS(a_col_in_range, clock, reset, col_ff < cols_ff)
   `LMF_ASSERT_ALWAYS(a_row_in_range, clock, reset, row_ff <= rows_ff + CNT_BITS'(1))
   `LMF_ASSERT_NEXT(a_done_restarts, clock, reset, take && ctrl0.done, {row_ff, col_ff} == '0)

endmodule

`default_nettype wire
